FILE: design/gda_pkg.sv
// Shared widths, calendar constants, reciprocals and helper functions for the date pipeline.
package gda_pkg;

   localparam int STAGES       = 13;
   localparam int FRONT_STAGES = 3;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int OFFSET_W = 23;
   localparam int DIFF_W   = 22;
   localparam int SERIAL_W = 23;
   localparam int DAYNUM_W = 24;

   localparam int DAYS_400 = 146097;
   localparam int DAYS_100 = 36524;
   localparam int DAYS_4   = 1461;
   localparam int DAYS_1   = 365;

   localparam int             RECIP_100_SHIFT = 19;
   localparam logic [12:0]    RECIP_100       = 13'(((64'd1 << 19) + 64'd99) / 64'd100);
   localparam int             RECIP_400Y_SHIFT = 32;
   localparam logic [14:0]    RECIP_400Y      = 15'((64'd1 << 32) / 64'd146097);
   localparam int             RECIP_4Y_SHIFT  = 20;
   localparam logic [9:0]     RECIP_4Y        = 10'((64'd1 << 20) / 64'd1461);

   localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC    = 4'd12;

   typedef struct packed {
      logic              cmd;
      logic              ok;
      logic [DIFF_W-1:0] diff;
   } side_type;

   function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] month);
      logic [8:0] days;
      case (month)
         4'd1:    days = 9'd0;
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
      logic [DAY_W-1:0] days;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    days = 5'd30;
         4'd2:    days = leap ? 5'd29 : 5'd28;
         default: days = 5'd0;
      endcase
      return days;
   endfunction

endpackage

FILE: design/gda_flow.sv
// Stage valid bits and the ripple stall chain that lets bubbles close up.
module gda_flow (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [gda_pkg::STAGES-1:0]   stage_en
);
   import gda_pkg::*;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] upstream;
   logic [STAGES-1:0] ready;

   assign upstream = {valid_ff[STAGES-2:0], req_valid};

   assign ready[STAGES-1] = !valid_ff[STAGES-1] || !rsp_stall;
   for (genvar i = 0; i < STAGES - 1; i++) begin : g_ready
      assign ready[i] = !valid_ff[i] || ready[i+1];
   end

   assign stage_en  = upstream & ready;
   assign valid_in  = (ready & upstream) | (~ready & valid_ff);
   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

FILE: design/gda_date_serial.sv
// Three stages that check one date and turn it into a day count from 0001-01-01.
module gda_date_serial #(
   parameter int MAX_YEAR = 9999
) (
   input  logic                                 clock,
   input  logic [gda_pkg::FRONT_STAGES-1:0]     stage_en,
   input  logic [gda_pkg::YEAR_W-1:0]           year,
   input  logic [gda_pkg::MONTH_W-1:0]          month,
   input  logic [gda_pkg::DAY_W-1:0]            day,
   output logic [gda_pkg::SERIAL_W-1:0]         serial,
   output logic                                 ok
);
   import gda_pkg::*;

   logic [YEAR_W-1:0]             prev_in;
   logic [YEAR_W+RECIP_100_SHIFT-6:0] prod_100;
   logic [7:0]                    cent_in;
   logic                          year_ok_in;
   logic [YEAR_W-1:0]             prev_ff;
   logic [7:0]                    cent_ff;
   logic                          year_ok0_ff;
   logic [MONTH_W-1:0]            month0_ff;
   logic [DAY_W-1:0]              day0_ff;

   logic [YEAR_W-1:0]             hundreds;
   logic [6:0]                    rem100_in;
   logic [SERIAL_W-1:0]           base_in;
   logic [6:0]                    rem100_ff;
   logic [SERIAL_W-1:0]           base_ff;
   logic [1:0]                    prev_lo_ff;
   logic [1:0]                    cent_lo_ff;
   logic                          year_ok1_ff;
   logic [MONTH_W-1:0]            month1_ff;
   logic [DAY_W-1:0]              day1_ff;

   logic                          leap;
   logic                          ok_in;
   logic [SERIAL_W-1:0]           serial_in;
   logic                          ok_ff;
   logic [SERIAL_W-1:0]           serial_ff;

   always_comb begin
      prev_in    = year - 14'd1;
      prod_100   = (YEAR_W+RECIP_100_SHIFT-5)'(prev_in) * (YEAR_W+RECIP_100_SHIFT-5)'(RECIP_100);
      cent_in    = prod_100[RECIP_100_SHIFT +: 8];
      year_ok_in = (year != '0) && (32'(year) <= 32'(MAX_YEAR));
   end

   always_comb begin
      hundreds  = 14'(cent_ff) * 14'd100;
      rem100_in = 7'(prev_ff - hundreds);
      base_in   = SERIAL_W'(prev_ff) * SERIAL_W'(DAYS_1) + SERIAL_W'(prev_ff[YEAR_W-1:2])
                  - SERIAL_W'(cent_ff) + SERIAL_W'(cent_ff[7:2]);
   end

   always_comb begin
      leap      = (prev_lo_ff == 2'd3) && ((rem100_ff != 7'd99) || (cent_lo_ff == 2'd3));
      ok_in     = year_ok1_ff && (month1_ff != '0) && (month1_ff <= MONTH_DEC)
                  && (day1_ff != '0) && (day1_ff <= month_days(month1_ff, leap));
      serial_in = base_ff + SERIAL_W'(days_before(month1_ff))
                  + SERIAL_W'(leap && (month1_ff > MONTH_FEB)) + SERIAL_W'(day1_ff)
                  - SERIAL_W'(1);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         prev_ff     <= prev_in;
         cent_ff     <= cent_in;
         year_ok0_ff <= year_ok_in;
         month0_ff   <= month;
         day0_ff     <= day;
      end
      if (stage_en[1]) begin
         rem100_ff   <= rem100_in;
         base_ff     <= base_in;
         prev_lo_ff  <= prev_ff[1:0];
         cent_lo_ff  <= cent_ff[1:0];
         year_ok1_ff <= year_ok0_ff;
         month1_ff   <= month0_ff;
         day1_ff     <= day0_ff;
      end
      if (stage_en[2]) begin
         ok_ff     <= ok_in;
         serial_ff <= serial_in;
      end
   end

   assign serial = serial_ff;
   assign ok     = ok_ff;

endmodule

FILE: design/gda_to_date.sv
// Stages that form the difference or the moved day count and split it back into a date.
module gda_to_date #(
   parameter int MAX_YEAR = 9999
) (
   input  logic                                                   clock,
   input  logic [gda_pkg::STAGES-1:gda_pkg::FRONT_STAGES]         stage_en,
   input  logic                                                   cmd,
   input  logic signed [gda_pkg::OFFSET_W-1:0]                    day_offset,
   input  logic [gda_pkg::SERIAL_W-1:0]                           first_serial,
   input  logic                                                   first_ok,
   input  logic [gda_pkg::SERIAL_W-1:0]                           second_serial,
   input  logic                                                   second_ok,
   output logic                                                   rsp_valid_res,
   output logic [gda_pkg::DIFF_W-1:0]                             rsp_day_difference,
   output logic [gda_pkg::YEAR_W-1:0]                             rsp_result_year,
   output logic [gda_pkg::MONTH_W-1:0]                            rsp_result_month,
   output logic [gda_pkg::DAY_W-1:0]                              rsp_result_day
);
   import gda_pkg::*;

   localparam int LAST_SERIAL = 365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100
                                + MAX_YEAR / 400 - 1;
   localparam int PROD400_W = DAYNUM_W + 15;
   localparam int PROD4_W   = 16 + 10;

   logic [SERIAL_W:0]         gap;
   logic [DAYNUM_W:0]         moved;
   logic                      ok3_in;
   logic [SERIAL_W-1:0]       diff3_in;
   logic                      cmd3_ff;
   logic                      ok3_ff;
   logic [SERIAL_W-1:0]       diff3_ff;
   logic [DAYNUM_W-1:0]       daynum3_ff;

   logic [PROD400_W-1:0]      prod400;
   side_type                  side4_in;
   logic [6:0]                q400e4_in;
   side_type                  side_ff [4:11];
   logic [DAYNUM_W-1:0]       daynum4_ff;
   logic [6:0]                q400e4_ff;

   logic [DAYNUM_W-1:0]       span5;
   logic [18:0]               rem5_in;
   logic [18:0]               rem5_ff;
   logic [6:0]                q400_ff [5:10];

   logic [6:0]                q400_6_in;
   logic [17:0]               rem6_in;
   logic [17:0]               rem6_ff;

   logic [1:0]                cent7_in;
   logic [15:0]               rem7_in;
   logic [15:0]               rem7_ff;
   logic [1:0]                cent_ff [7:10];

   logic [PROD4_W-1:0]        prod4;
   logic [4:0]                q4e8_in;
   logic [15:0]               rem8_ff;
   logic [4:0]                q4_ff [8:10];

   logic [11:0]               rem9_in;
   logic [11:0]               rem9_ff;

   logic [4:0]                q4_10_in;
   logic [10:0]               rem10_in;
   logic [10:0]               rem10_ff;

   logic [1:0]                yr11;
   logic [8:0]                rem11_in;
   logic [15:0]               year11_in;
   logic                      leap11_in;
   logic [8:0]                rem11_ff;
   logic [15:0]               year11_ff;
   logic                      leap11_ff;

   logic [8:0]                thresh;
   logic [8:0]                lead;
   logic [MONTH_W-1:0]        month12_in;
   logic [DAY_W-1:0]          day12_in;
   logic                      valid_res_in;
   logic [DIFF_W-1:0]         difference_in;
   logic [YEAR_W-1:0]         res_year_in;
   logic [MONTH_W-1:0]        res_month_in;
   logic [DAY_W-1:0]          res_day_in;
   logic                      valid_res_ff;
   logic [DIFF_W-1:0]         difference_ff;
   logic [YEAR_W-1:0]         res_year_ff;
   logic [MONTH_W-1:0]        res_month_ff;
   logic [DAY_W-1:0]          res_day_ff;

   always_comb begin
      gap      = {1'b0, first_serial} - {1'b0, second_serial};
      diff3_in = gap[SERIAL_W] ? SERIAL_W'(-gap) : gap[SERIAL_W-1:0];
      moved    = {2'b00, first_serial}
                 + {{(DAYNUM_W+1-OFFSET_W){day_offset[OFFSET_W-1]}}, day_offset};
      ok3_in   = first_ok && (cmd ? (!moved[DAYNUM_W]
                                     && (32'(moved) <= 32'(LAST_SERIAL)))
                                  : second_ok);
   end

   always_comb begin
      prod400   = PROD400_W'(daynum3_ff) * PROD400_W'(RECIP_400Y);
      q400e4_in = prod400[RECIP_400Y_SHIFT +: 7];
      side4_in  = '{cmd:  cmd3_ff,
                    ok:   ok3_ff && (cmd3_ff || !diff3_ff[SERIAL_W-1]),
                    diff: diff3_ff[DIFF_W-1:0]};
   end

   always_comb begin
      span5   = DAYNUM_W'(q400e4_ff) * DAYNUM_W'(DAYS_400);
      rem5_in = 19'(daynum4_ff - span5);
   end

   always_comb begin
      if (rem5_ff >= 19'(DAYS_400)) begin
         q400_6_in = q400_ff[5] + 7'd1;
         rem6_in   = 18'(rem5_ff - 19'(DAYS_400));
      end else begin
         q400_6_in = q400_ff[5];
         rem6_in   = rem5_ff[17:0];
      end
   end

   always_comb begin
      cent7_in = 2'(rem6_ff >= 18'(DAYS_100)) + 2'(rem6_ff >= 18'(2 * DAYS_100))
                 + 2'(rem6_ff >= 18'(3 * DAYS_100));
      rem7_in  = 16'(rem6_ff - 18'(cent7_in) * 18'(DAYS_100));
   end

   always_comb begin
      prod4   = PROD4_W'(rem7_ff) * PROD4_W'(RECIP_4Y);
      q4e8_in = prod4[RECIP_4Y_SHIFT +: 5];
   end

   always_comb begin
      rem9_in = 12'(rem8_ff - 16'(q4_ff[8]) * 16'(DAYS_4));
   end

   always_comb begin
      if (rem9_ff >= 12'(DAYS_4)) begin
         q4_10_in = q4_ff[9] + 5'd1;
         rem10_in = 11'(rem9_ff - 12'(DAYS_4));
      end else begin
         q4_10_in = q4_ff[9];
         rem10_in = rem9_ff[10:0];
      end
   end

   always_comb begin
      yr11      = 2'(rem10_ff >= 11'(DAYS_1)) + 2'(rem10_ff >= 11'(2 * DAYS_1))
                  + 2'(rem10_ff >= 11'(3 * DAYS_1));
      rem11_in  = 9'(rem10_ff - 11'(yr11) * 11'(DAYS_1));
      year11_in = 16'd1 + 16'(q400_ff[10]) * 16'd400 + 16'(cent_ff[10]) * 16'd100
                  + 16'(q4_ff[10]) * 16'd4 + 16'(yr11);
      leap11_in = (yr11 == 2'd3) && ((q4_ff[10] != 5'd24) || (cent_ff[10] == 2'd3));
   end

   always_comb begin
      month12_in = 4'd1;
      thresh     = '0;
      for (int k = 2; k <= 12; k++) begin
         thresh = days_before(4'(k)) + 9'(leap11_ff && (k > 2));
         if (rem11_ff >= thresh) begin
            month12_in = month12_in + 4'd1;
         end
      end
      lead     = days_before(month12_in) + 9'(leap11_ff && (month12_in > MONTH_FEB));
      day12_in = 5'(rem11_ff - lead + 9'd1);

      valid_res_in  = side_ff[11].ok;
      difference_in = (side_ff[11].ok && !side_ff[11].cmd) ? side_ff[11].diff : '0;
      res_year_in   = (side_ff[11].ok && side_ff[11].cmd) ? year11_ff[YEAR_W-1:0] : '0;
      res_month_in  = (side_ff[11].ok && side_ff[11].cmd) ? month12_in : '0;
      res_day_in    = (side_ff[11].ok && side_ff[11].cmd) ? day12_in : '0;
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         cmd3_ff    <= cmd;
         ok3_ff     <= ok3_in;
         diff3_ff   <= diff3_in;
         daynum3_ff <= moved[DAYNUM_W-1:0];
      end
      if (stage_en[4]) begin
         side_ff[4] <= side4_in;
         daynum4_ff <= daynum3_ff;
         q400e4_ff  <= q400e4_in;
      end
      for (int k = 5; k <= 11; k++) begin
         if (stage_en[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
      if (stage_en[5]) begin
         rem5_ff    <= rem5_in;
         q400_ff[5] <= q400e4_ff;
      end
      if (stage_en[6]) begin
         rem6_ff    <= rem6_in;
         q400_ff[6] <= q400_6_in;
      end
      for (int k = 7; k <= 10; k++) begin
         if (stage_en[k]) begin
            q400_ff[k] <= q400_ff[k-1];
         end
      end
      if (stage_en[7]) begin
         rem7_ff    <= rem7_in;
         cent_ff[7] <= cent7_in;
      end
      for (int k = 8; k <= 10; k++) begin
         if (stage_en[k]) begin
            cent_ff[k] <= cent_ff[k-1];
         end
      end
      if (stage_en[8]) begin
         rem8_ff  <= rem7_ff;
         q4_ff[8] <= q4e8_in;
      end
      if (stage_en[9]) begin
         rem9_ff  <= rem9_in;
         q4_ff[9] <= q4_ff[8];
      end
      if (stage_en[10]) begin
         rem10_ff  <= rem10_in;
         q4_ff[10] <= q4_10_in;
      end
      if (stage_en[11]) begin
         rem11_ff  <= rem11_in;
         year11_ff <= year11_in;
         leap11_ff <= leap11_in;
      end
      if (stage_en[12]) begin
         valid_res_ff  <= valid_res_in;
         difference_ff <= difference_in;
         res_year_ff   <= res_year_in;
         res_month_ff  <= res_month_in;
         res_day_ff    <= res_day_in;
      end
   end

   assign rsp_valid_res      = valid_res_ff;
   assign rsp_day_difference = difference_ff;
   assign rsp_result_year    = res_year_ff;
   assign rsp_result_month   = res_month_ff;
   assign rsp_result_day     = res_day_ff;

endmodule

FILE: design/gregorian_date_arithmetic.sv
// Gregorian date difference and date offset pipeline, top level.
// Throughput is one transaction per cycle while rsp_stall is low; each of the 13 register stages holds one item.
// A stalled response holds the last stage and the full stages behind it; earlier stages keep filling any empty slots.
// Synchronous reset clears the stage valid bits; the datapath registers are not reset.
module gregorian_date_arithmetic #(
   parameter int MAX_YEAR = 9999
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_cmd,
   input  logic [gda_pkg::YEAR_W-1:0]          req_first_year,
   input  logic [gda_pkg::MONTH_W-1:0]         req_first_month,
   input  logic [gda_pkg::DAY_W-1:0]           req_first_day,
   input  logic [gda_pkg::YEAR_W-1:0]          req_second_year,
   input  logic [gda_pkg::MONTH_W-1:0]         req_second_month,
   input  logic [gda_pkg::DAY_W-1:0]           req_second_day,
   input  logic signed [gda_pkg::OFFSET_W-1:0] req_day_offset,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_valid_res,
   output logic [gda_pkg::DIFF_W-1:0]          rsp_day_difference,
   output logic [gda_pkg::YEAR_W-1:0]          rsp_result_year,
   output logic [gda_pkg::MONTH_W-1:0]         rsp_result_month,
   output logic [gda_pkg::DAY_W-1:0]           rsp_result_day
);
   import gda_pkg::*;

   logic [STAGES-1:0]          stage_en;
   logic [FRONT_STAGES-1:0]    cmd_ff;
   logic signed [OFFSET_W-1:0] offset_ff [FRONT_STAGES];
   logic [SERIAL_W-1:0]        first_serial;
   logic [SERIAL_W-1:0]        second_serial;
   logic                       first_ok;
   logic                       second_ok;

   gda_flow u_flow (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stage_en  (stage_en)
   );

   gda_date_serial #(
      .MAX_YEAR (MAX_YEAR)
   ) u_first (
      .clock    (clock),
      .stage_en (stage_en[FRONT_STAGES-1:0]),
      .year     (req_first_year),
      .month    (req_first_month),
      .day      (req_first_day),
      .serial   (first_serial),
      .ok       (first_ok)
   );

   gda_date_serial #(
      .MAX_YEAR (MAX_YEAR)
   ) u_second (
      .clock    (clock),
      .stage_en (stage_en[FRONT_STAGES-1:0]),
      .year     (req_second_year),
      .month    (req_second_month),
      .day      (req_second_day),
      .serial   (second_serial),
      .ok       (second_ok)
   );

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         cmd_ff[0]    <= req_cmd;
         offset_ff[0] <= req_day_offset;
      end
      for (int i = 1; i < FRONT_STAGES; i++) begin
         if (stage_en[i]) begin
            cmd_ff[i]    <= cmd_ff[i-1];
            offset_ff[i] <= offset_ff[i-1];
         end
      end
   end

   gda_to_date #(
      .MAX_YEAR (MAX_YEAR)
   ) u_to_date (
      .clock              (clock),
      .stage_en           (stage_en[STAGES-1:FRONT_STAGES]),
      .cmd                (cmd_ff[FRONT_STAGES-1]),
      .day_offset         (offset_ff[FRONT_STAGES-1]),
      .first_serial       (first_serial),
      .first_ok           (first_ok),
      .second_serial      (second_serial),
      .second_ok          (second_ok),
      .rsp_valid_res      (rsp_valid_res),
      .rsp_day_difference (rsp_day_difference),
      .rsp_result_year    (rsp_result_year),
      .rsp_result_month   (rsp_result_month),
      .rsp_result_day     (rsp_result_day)
   );

   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("Request stalled while the pipeline still had room.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_day_difference == '0 && rsp_result_year == '0
         && rsp_result_month == '0 && rsp_result_day == '0)
      else $error("Invalid response carries nonzero result fields.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_month != '0 |-> rsp_valid_res && rsp_result_month <= MONTH_DEC
         && rsp_result_day != '0 && rsp_day_difference == '0)
      else $error("Moved date response is malformed.");

endmodule
